FILE: hdl/ufr_pkg.sv
// ufr_pkg: shared types and constants for the union-find engine.
// Command and result words, operation codes, field widths.
// No dependencies.
`timescale 1ns / 1ps

package ufr_pkg;

  localparam int ELEM_W = 10;
  localparam int CNT_W  = 11;
  localparam int RANK_W = 4;

  localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

  localparam logic [1:0] KIND_UNION  = 2'd0;
  localparam logic [1:0] KIND_FIND   = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ELEM_W-1:0] elem_a;
    logic [ELEM_W-1:0] elem_b;
  } cmd_word_t;

  typedef struct packed {
    logic [ELEM_W-1:0] root_a;
    logic [ELEM_W-1:0] root_b;
    logic              merged;
    logic [CNT_W-1:0]  set_count;
    logic              bad_index;
  } res_word_t;

endpackage

FILE: hdl/ufr_table.sv
// ufr_table: single-port-write, single-port-read table of parent links and ranks.
// Read data registered; one write and one read per cycle.
// No dependencies.
`timescale 1ns / 1ps

module ufr_table #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10,
  parameter int DATA_W = 14
) (
  input  logic              clk,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: hdl/union_find_by_rank_unit.sv
// union_find_by_rank_unit: disjoint-set engine, union by rank with full path compression.
// Depends on ufr_pkg and ufr_table.
// Find walks the parent links to the root, then points each link on the path at the root;
// union walks both, links the roots; clear sweeps; bad index or unused kind end in idle.
// Throughput: one word at a time, every table access goes through the one table port pair.
// Reset: a sweep sets each entry to point at itself with rank zero, busy is held high meanwhile.
// The done strobe lasts one cycle and cannot be stalled.
`timescale 1ns / 1ps

module union_find_by_rank_unit #(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  ufr_pkg::cmd_word_t              cmd,
  output logic                            done,
  output ufr_pkg::res_word_t              result,
  input  logic                            cfg_we,
  input  logic [ufr_pkg::CNT_W-1:0]       cfg_wdata
);

  localparam int IDX_W  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int DATA_W = IDX_W + ufr_pkg::RANK_W;
  localparam logic [16:0] MAX_EL = 17'(MAX_ELEMENTS);
  localparam logic [ufr_pkg::CNT_W-1:0] CNT_RESET =
    ufr_pkg::CNT_W'((MAX_ELEMENTS < 1024) ? MAX_ELEMENTS : 1024);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ELEMENTS - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_WALK, S_COMP, S_LINK, S_BUMP, S_SWEEP
  } state_t;

  state_t                         state;
  logic [ufr_pkg::CNT_W-1:0]      element_count;
  logic [ufr_pkg::CNT_W-1:0]      live_sets;
  logic [ufr_pkg::CNT_W-1:0]      eff;
  logic [IDX_W-1:0]               cur, origin, root, ra, b_addr, sweep_idx;
  logic [ufr_pkg::RANK_W-1:0]     root_rank, rank_a;
  logic                           is_union, phase_b, is_clear;
  logic [ufr_pkg::ELEM_W-1:0]     res_root_a, res_root_b;
  logic                           res_merged, res_bad;

  logic [IDX_W-1:0]               rd_addr, wr_addr;
  logic [DATA_W-1:0]              rd_data, wr_data;
  logic                           wr_en;
  logic [IDX_W-1:0]               rd_link;
  logic [ufr_pkg::RANK_W-1:0]     rd_rank;
  logic                           a_bad, b_bad;

  ufr_table #(
    .DEPTH (MAX_ELEMENTS),
    .ADDR_W(IDX_W),
    .DATA_W(DATA_W)
  ) u_table (
    .clk    (clk),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  assign rd_link = rd_data[IDX_W-1:0];
  assign rd_rank = rd_data[IDX_W +: ufr_pkg::RANK_W];

  // element count limited to the table depth
  assign eff = ({6'b0, element_count} > MAX_EL) ? MAX_EL[ufr_pkg::CNT_W-1:0] : element_count;
  assign a_bad = ({1'b0, cmd.elem_a} >= eff);
  assign b_bad = ({1'b0, cmd.elem_b} >= eff);

  assign busy = (state != S_IDLE);

  always_comb begin
    result.root_a    = res_root_a;
    result.root_b    = res_root_b;
    result.merged    = res_merged;
    result.set_count = live_sets;
    result.bad_index = res_bad;
  end

  // table port steering
  always_comb begin
    rd_addr = cur;
    wr_en   = 1'b0;
    wr_addr = cur;
    wr_data = {rd_rank, root};
    case (state)
      S_IDLE: begin
        rd_addr = IDX_W'(cmd.elem_a);
      end
      S_WALK: begin
        rd_addr = (rd_link == cur) ? origin : rd_link;
      end
      S_COMP: begin
        if (cur == root) begin
          rd_addr = b_addr;
        end else begin
          wr_en   = 1'b1;
          wr_addr = cur;
          wr_data = {rd_rank, root};
          rd_addr = rd_link;
        end
      end
      S_LINK: begin
        wr_en = 1'b1;
        if (rank_a > root_rank) begin
          wr_addr = root;
          wr_data = {root_rank, ra};
        end else begin
          wr_addr = ra;
          wr_data = {rank_a, root};
        end
      end
      S_BUMP: begin
        wr_en   = 1'b1;
        wr_addr = root;
        wr_data = {root_rank + 1'b1, root};
      end
      S_SWEEP: begin
        wr_en   = 1'b1;
        wr_addr = sweep_idx;
        wr_data = {{ufr_pkg::RANK_W{1'b0}}, sweep_idx};
      end
      default: begin
        rd_addr = cur;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_SWEEP;
      sweep_idx     <= '0;
      is_clear      <= 1'b0;
      element_count <= 11'd1024;
      live_sets     <= CNT_RESET;
      done          <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        element_count <= cfg_wdata;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            res_root_a <= '0;
            res_root_b <= '0;
            res_merged <= 1'b0;
            res_bad    <= 1'b0;
            is_union   <= (cmd.kind == ufr_pkg::KIND_UNION);
            phase_b    <= 1'b0;
            cur        <= IDX_W'(cmd.elem_a);
            origin     <= IDX_W'(cmd.elem_a);
            b_addr     <= IDX_W'(cmd.elem_b);
            case (cmd.kind)
              ufr_pkg::KIND_UNION: begin
                if (a_bad || b_bad) begin
                  res_bad <= 1'b1;
                  done    <= 1'b1;
                end else begin
                  state <= S_WALK;
                end
              end
              ufr_pkg::KIND_FIND: begin
                if (a_bad) begin
                  res_bad <= 1'b1;
                  done    <= 1'b1;
                end else begin
                  state <= S_WALK;
                end
              end
              ufr_pkg::KIND_CLEAR: begin
                sweep_idx <= '0;
                is_clear  <= 1'b1;
                state     <= S_SWEEP;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_WALK: begin
          if (rd_link == cur) begin
            root      <= cur;
            root_rank <= rd_rank;
            cur       <= origin;
            state     <= S_COMP;
          end else begin
            cur <= rd_link;
          end
        end
        S_COMP: begin
          if (cur == root) begin
            if (is_union && !phase_b) begin
              ra      <= root;
              rank_a  <= root_rank;
              phase_b <= 1'b1;
              cur     <= b_addr;
              origin  <= b_addr;
              state   <= S_WALK;
            end else if (is_union) begin
              if (ra == root) begin
                res_root_a <= ufr_pkg::ELEM_W'(root);
                res_root_b <= ufr_pkg::ELEM_W'(root);
                done       <= 1'b1;
                state      <= S_IDLE;
              end else begin
                state <= S_LINK;
              end
            end else begin
              res_root_a <= ufr_pkg::ELEM_W'(root);
              done       <= 1'b1;
              state      <= S_IDLE;
            end
          end else begin
            cur <= rd_link;
          end
        end
        S_LINK: begin
          res_merged <= 1'b1;
          if (live_sets != '0) begin
            live_sets <= live_sets - 1'b1;
          end
          if (rank_a > root_rank) begin
            res_root_a <= ufr_pkg::ELEM_W'(ra);
            res_root_b <= ufr_pkg::ELEM_W'(ra);
            done       <= 1'b1;
            state      <= S_IDLE;
          end else begin
            res_root_a <= ufr_pkg::ELEM_W'(root);
            res_root_b <= ufr_pkg::ELEM_W'(root);
            if (rank_a == root_rank && root_rank != ufr_pkg::RANK_MAX) begin
              state <= S_BUMP;
            end else begin
              done  <= 1'b1;
              state <= S_IDLE;
            end
          end
        end
        S_BUMP: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_SWEEP: begin
          sweep_idx <= sweep_idx + 1'b1;
          if (sweep_idx == LAST_IDX) begin
            if (is_clear) begin
              live_sets <= eff;
              done      <= 1'b1;
            end
            is_clear <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a merge always reports one common root
  a_merge_roots: assert property (@(posedge clk) disable iff (rst)
    done && result.merged |-> result.root_a == result.root_b)
    else $error("merged word with differing roots");

  // a flagged index leaves the result fields empty
  a_bad_empty: assert property (@(posedge clk) disable iff (rst)
    done && result.bad_index |-> result.root_a == '0 && result.root_b == '0 && !result.merged)
    else $error("bad index word carries roots");

  // an accepted word either completes at once or holds the engine busy
  a_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || done)
    else $error("accepted word dropped");

  // table writes only come from working states
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !wr_en)
    else $error("table written while idle");

endmodule
